FILE: hw/rtl/aswg_pkg.sv
// Shared constants, types and saturation helpers for the affine subset warp block.
// Used by the channel interfaces and every module of the block; depends on nothing.
package aswg_pkg;

  localparam int NUM_STG    = 8;
  localparam int NUM_REGS   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 14;
  localparam int GRAD_W     = 16;
  localparam int MAP_W      = 40;
  localparam int TERM_W     = 48;

  // Unit ratio in Q2.30, widened to hold one plus any stretch value.
  localparam logic signed [32:0] Q30_ONE     = 33'sh0_4000_0000;
  localparam logic signed [31:0] ROT_COS_RST = 32'sh4000_0000;

  localparam logic signed [63:0] TERM_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] TERM_MIN = -64'sd140737488355328;
  localparam logic signed [63:0] MAP_MAX  = 64'sd549755813887;
  localparam logic signed [63:0] MAP_MIN  = -64'sd549755813888;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_COS    = 3'd0,
    REG_ROT_SIN    = 3'd1,
    REG_STRETCH_XX = 3'd2,
    REG_STRETCH_YY = 3'd3,
    REG_SHEAR_XY   = 3'd4,
    REG_DISP_U     = 3'd5,
    REG_DISP_V     = 3'd6
  } reg_idx_t;

  typedef logic [NUM_STG-1:0] stg_vec_t;

  typedef struct packed {
    logic signed [31:0] rot_cos;
    logic signed [31:0] rot_sin;
    logic signed [31:0] stretch_xx;
    logic signed [31:0] stretch_yy;
    logic signed [31:0] shear_xy;
    logic signed [31:0] disp_u;
    logic signed [31:0] disp_v;
  } cfg_t;

  localparam cfg_t CFG_RST = '{rot_cos: ROT_COS_RST, default: '0};

  // Rotation and gradient partial products leaving the front section.
  typedef struct packed {
    logic signed [56:0] cbxl;
    logic signed [55:0] cbxh;
    logic signed [56:0] sbyl;
    logic signed [55:0] sbyh;
    logic signed [56:0] sbxl;
    logic signed [55:0] sbxh;
    logic signed [56:0] cbyl;
    logic signed [55:0] cbyh;
    logic signed [66:0] cggx;
    logic signed [66:0] sggy;
    logic signed [66:0] cggy;
    logic signed [66:0] sggx;
    logic signed [34:0] ggx;
    logic signed [34:0] ggy;
    logic signed [14:0] dx;
    logic signed [14:0] dy;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } s3_t;

  // Mapped position, finished stretch terms and rotation term partial products.
  typedef struct packed {
    logic signed [37:0]       mx;
    logic signed [37:0]       my;
    logic signed [59:0]       tal;
    logic signed [60:0]       tah;
    logic signed [59:0]       tbl;
    logic signed [60:0]       tbh;
    logic signed [TERM_W-1:0] texx;
    logic signed [TERM_W-1:0] teyy;
    logic signed [TERM_W-1:0] tsh;
    logic signed [34:0]       ggx;
    logic signed [34:0]       ggy;
  } s6_t;

  typedef struct packed {
    logic signed [MAP_W-1:0]  mapped_x;
    logic signed [MAP_W-1:0]  mapped_y;
    logic signed [TERM_W-1:0] term_u;
    logic signed [TERM_W-1:0] term_v;
    logic signed [TERM_W-1:0] term_rot;
    logic signed [TERM_W-1:0] term_exx;
    logic signed [TERM_W-1:0] term_eyy;
    logic signed [TERM_W-1:0] term_shear;
  } res_t;

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [63:0] v);
    logic signed [TERM_W-1:0] r;
    if (v > TERM_MAX) begin
      r = TERM_MAX[TERM_W-1:0];
    end else if (v < TERM_MIN) begin
      r = TERM_MIN[TERM_W-1:0];
    end else begin
      r = v[TERM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [MAP_W-1:0] sat_map(input logic signed [63:0] v);
    logic signed [MAP_W-1:0] r;
    if (v > MAP_MAX) begin
      r = MAP_MAX[MAP_W-1:0];
    end else if (v < MAP_MIN) begin
      r = MAP_MIN[MAP_W-1:0];
    end else begin
      r = v[MAP_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/aswg_ifs.sv
// Valid/ready channel interfaces for pixel input, result output and register writes.
// Depends on aswg_pkg for field widths.
interface aswg_in_if;
  import aswg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [COORD_W-1:0]        pix_x;
  logic [COORD_W-1:0]        pix_y;
  logic [COORD_W-1:0]        centre_x;
  logic [COORD_W-1:0]        centre_y;
  logic signed [GRAD_W-1:0]  grad_x;
  logic signed [GRAD_W-1:0]  grad_y;
  logic                      rotate_grads;
  modport source (output valid, pix_x, pix_y, centre_x, centre_y, grad_x, grad_y,
                  rotate_grads, input ready);
  modport sink (input valid, pix_x, pix_y, centre_x, centre_y, grad_x, grad_y,
                rotate_grads, output ready);
endinterface

interface aswg_out_if;
  import aswg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [MAP_W-1:0]   mapped_x;
  logic signed [MAP_W-1:0]   mapped_y;
  logic signed [TERM_W-1:0]  term_u;
  logic signed [TERM_W-1:0]  term_v;
  logic signed [TERM_W-1:0]  term_rot;
  logic signed [TERM_W-1:0]  term_exx;
  logic signed [TERM_W-1:0]  term_eyy;
  logic signed [TERM_W-1:0]  term_shear;
  modport source (output valid, mapped_x, mapped_y, term_u, term_v, term_rot, term_exx,
                  term_eyy, term_shear, input ready);
  modport sink (input valid, mapped_x, mapped_y, term_u, term_v, term_rot, term_exx,
                term_eyy, term_shear, output ready);
endinterface

interface aswg_cfg_if;
  import aswg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/aswg_cfg_regs.sv
// Register file for rotation, stretch, shear and displacement settings.
// Depends on aswg_pkg.
module aswg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [aswg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aswg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             cfg_ready,
  output aswg_pkg::cfg_t                   cfg
);
  import aswg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROT_COS:    cfg_nxt.rot_cos    = cfg_data;
        REG_ROT_SIN:    cfg_nxt.rot_sin    = cfg_data;
        REG_STRETCH_XX: cfg_nxt.stretch_xx = cfg_data;
        REG_STRETCH_YY: cfg_nxt.stretch_yy = cfg_data;
        REG_SHEAR_XY:   cfg_nxt.shear_xy   = cfg_data;
        REG_DISP_U:     cfg_nxt.disp_u     = cfg_data;
        REG_DISP_V:     cfg_nxt.disp_v     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && (int'(cfg_index) >= NUM_REGS) |=> $stable(cfg_r))
    else $error("register write beyond the register list changed a setting");

endmodule

FILE: hw/rtl/aswg_pipe_ctl.sv
// Valid bits and stage enables for the eight-stage pipeline; bubbles collapse under stall.
// Depends on aswg_pkg.
module aswg_pipe_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output aswg_pkg::stg_vec_t en
);
  import aswg_pkg::*;

  stg_vec_t v_r;
  stg_vec_t v_nxt;
  stg_vec_t adv;
  stg_vec_t src;

  always_comb begin
    adv[NUM_STG-1] = ~v_r[NUM_STG-1] | out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = ~v_r[k] | adv[k+1];
    end
    src = {v_r[NUM_STG-2:0], in_valid};
    en  = adv & src;
    for (int k = 0; k < NUM_STG; k++) begin
      v_nxt[k] = adv[k] ? src[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NUM_STG-1];

  a_block_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input held off while a pipeline stage is empty");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(v_r) == $past($countones(v_r))
                + int'($past(in_valid && in_ready))
                - int'($past(out_valid && out_ready))))
    else $error("items in flight do not match the transfers seen");

endmodule

FILE: hw/rtl/aswg_front.sv
// Stages one to three: subset offsets, stretch and shear, gradient rotation and
// rounding, then the partial products of the warp rotation. Depends on aswg_pkg.
module aswg_front (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  aswg_pkg::cfg_t                    cfg,
  input  logic [aswg_pkg::COORD_W-1:0]      pix_x,
  input  logic [aswg_pkg::COORD_W-1:0]      pix_y,
  input  logic [aswg_pkg::COORD_W-1:0]      centre_x,
  input  logic [aswg_pkg::COORD_W-1:0]      centre_y,
  input  logic signed [aswg_pkg::GRAD_W-1:0] grad_x,
  input  logic signed [aswg_pkg::GRAD_W-1:0] grad_y,
  input  logic                              rotate_grads,
  output aswg_pkg::s3_t                     s3
);
  import aswg_pkg::*;

  logic signed [31:0] cos_s, sin_s, gxy_s;
  logic signed [32:0] one_exx, one_eyy;

  logic signed [14:0] dx_nxt, dy_nxt, dx1_r, dy1_r, dx2_r, dy2_r;
  logic [COORD_W-1:0] cx1_r, cy1_r, cx2_r, cy2_r;
  logic signed [47:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic signed [47:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [47:0] gcx_nxt, gsy_nxt, gsx_nxt, gcy_nxt;
  logic signed [47:0] gcx1_r, gsy1_r, gsx1_r, gcy1_r;
  logic signed [GRAD_W-1:0] gx1_r, gy1_r;
  logic               rot1_r;

  logic signed [48:0] g30x, g30y, g30x_rnd, g30y_rnd;
  logic signed [47:0] bx_nxt, by_nxt, bx2_r, by2_r;
  logic signed [34:0] ggx_nxt, ggy_nxt, ggx2_r, ggy2_r;

  logic signed [24:0] bxl, byl;
  logic signed [23:0] bxh, byh;
  s3_t s3_nxt;
  s3_t s3_r;

  assign cos_s   = cfg.rot_cos;
  assign sin_s   = cfg.rot_sin;
  assign gxy_s   = cfg.shear_xy;
  assign one_exx = Q30_ONE + 33'($signed(cfg.stretch_xx));
  assign one_eyy = Q30_ONE + 33'($signed(cfg.stretch_yy));

  // Stage one.
  assign dx_nxt  = $signed({1'b0, pix_x}) - $signed({1'b0, centre_x});
  assign dy_nxt  = $signed({1'b0, pix_y}) - $signed({1'b0, centre_y});
  assign p1_nxt  = one_exx * dx_nxt;
  assign p2_nxt  = gxy_s * dy_nxt;
  assign p3_nxt  = one_eyy * dy_nxt;
  assign p4_nxt  = gxy_s * dx_nxt;
  assign gcx_nxt = cos_s * grad_x;
  assign gsy_nxt = sin_s * grad_y;
  assign gsx_nxt = sin_s * grad_x;
  assign gcy_nxt = cos_s * grad_y;

  // Stage two.
  assign bx_nxt = p1_r + p2_r;
  assign by_nxt = p3_r + p4_r;

  always_comb begin
    if (rot1_r) begin
      g30x = 49'(gcx1_r) - 49'(gsy1_r);
      g30y = 49'(gsx1_r) + 49'(gcy1_r);
    end else begin
      g30x = {{3{gx1_r[GRAD_W-1]}}, gx1_r, 30'd0};
      g30y = {{3{gy1_r[GRAD_W-1]}}, gy1_r, 30'd0};
    end
    g30x_rnd = g30x + 49'sd8192;
    g30y_rnd = g30y + 49'sd8192;
    ggx_nxt  = $signed(g30x_rnd[48:14]);
    ggy_nxt  = $signed(g30y_rnd[48:14]);
  end

  // Stage three.
  assign bxl = $signed({1'b0, bx2_r[23:0]});
  assign bxh = $signed(bx2_r[47:24]);
  assign byl = $signed({1'b0, by2_r[23:0]});
  assign byh = $signed(by2_r[47:24]);

  always_comb begin
    s3_nxt.cbxl = cos_s * bxl;
    s3_nxt.cbxh = cos_s * bxh;
    s3_nxt.sbyl = sin_s * byl;
    s3_nxt.sbyh = sin_s * byh;
    s3_nxt.sbxl = sin_s * bxl;
    s3_nxt.sbxh = sin_s * bxh;
    s3_nxt.cbyl = cos_s * byl;
    s3_nxt.cbyh = cos_s * byh;
    s3_nxt.cggx = cos_s * ggx2_r;
    s3_nxt.sggy = sin_s * ggy2_r;
    s3_nxt.cggy = cos_s * ggy2_r;
    s3_nxt.sggx = sin_s * ggx2_r;
    s3_nxt.ggx  = ggx2_r;
    s3_nxt.ggy  = ggy2_r;
    s3_nxt.dx   = dx2_r;
    s3_nxt.dy   = dy2_r;
    s3_nxt.cx   = cx2_r;
    s3_nxt.cy   = cy2_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx1_r  <= dx_nxt;
      dy1_r  <= dy_nxt;
      cx1_r  <= centre_x;
      cy1_r  <= centre_y;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      p3_r   <= p3_nxt;
      p4_r   <= p4_nxt;
      gcx1_r <= gcx_nxt;
      gsy1_r <= gsy_nxt;
      gsx1_r <= gsx_nxt;
      gcy1_r <= gcy_nxt;
      gx1_r  <= grad_x;
      gy1_r  <= grad_y;
      rot1_r <= rotate_grads;
    end
    if (en[1]) begin
      bx2_r  <= bx_nxt;
      by2_r  <= by_nxt;
      ggx2_r <= ggx_nxt;
      ggy2_r <= ggy_nxt;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

FILE: hw/rtl/aswg_mid.sv
// Stages four to six: warp rotation, stretch and shear terms, mapped position and the
// partial products of the rotation term. Depends on aswg_pkg.
module aswg_mid (
  input  logic           clk,
  input  logic [2:0]     en,
  input  aswg_pkg::cfg_t cfg,
  input  aswg_pkg::s3_t  s3,
  output aswg_pkg::s6_t  s6
);
  import aswg_pkg::*;

  logic signed [79:0] cbx_nxt, sby_nxt, sbx_nxt, cby_nxt;
  logic signed [79:0] cbx4_r, sby4_r, sbx4_r, cby4_r;
  logic signed [66:0] rcgx, rsgy, rcgy, rsgx;
  logic signed [36:0] ex_nxt, ey_nxt, ex4_r, ey4_r;
  logic signed [34:0] ggx4_r, ggy4_r, ggx5_r, ggy5_r;
  logic signed [14:0] dx4_r, dy4_r;
  logic [COORD_W-1:0] cx4_r, cy4_r, cx5_r, cy5_r;

  logic signed [79:0] rcbx, rsby, rsbx, rcby;
  logic signed [49:0] rx_nxt, ry_nxt, rx5_r, ry5_r;
  logic signed [51:0] exdx_nxt, eydy_nxt, exdy_nxt, eydx_nxt;
  logic signed [51:0] exdx5_r, eydy5_r, exdy5_r, eydx5_r;

  logic signed [51:0] mxs, mys;
  logic signed [49:0] nry;
  logic signed [52:0] shear_sum;
  s6_t s6_nxt;
  s6_t s6_r;

  // Stage four.
  always_comb begin
    cbx_nxt = {s3.cbxh, 24'd0} + 80'($signed(s3.cbxl));
    sby_nxt = {s3.sbyh, 24'd0} + 80'($signed(s3.sbyl));
    sbx_nxt = {s3.sbxh, 24'd0} + 80'($signed(s3.sbxl));
    cby_nxt = {s3.cbyh, 24'd0} + 80'($signed(s3.cbyl));
    rcgx    = $signed(s3.cggx) + 67'sd536870912;
    rsgy    = $signed(s3.sggy) + 67'sd536870912;
    rcgy    = $signed(s3.cggy) + 67'sd536870912;
    rsgx    = $signed(s3.sggx) + 67'sd536870912;
    ex_nxt  = $signed(rcgx[66:30]) + $signed(rsgy[66:30]);
    ey_nxt  = $signed(rcgy[66:30]) - $signed(rsgx[66:30]);
  end

  // Stage five.
  always_comb begin
    rcbx     = cbx4_r + 80'sd536870912;
    rsby     = sby4_r + 80'sd536870912;
    rsbx     = sbx4_r + 80'sd536870912;
    rcby     = cby4_r + 80'sd536870912;
    rx_nxt   = $signed(rcbx[79:30]) - $signed(rsby[79:30]);
    ry_nxt   = $signed(rsbx[79:30]) + $signed(rcby[79:30]);
    exdx_nxt = ex4_r * dx4_r;
    eydy_nxt = ey4_r * dy4_r;
    exdy_nxt = ex4_r * dy4_r;
    eydx_nxt = ey4_r * dx4_r;
  end

  // Stage six.
  always_comb begin
    mxs = 52'(rx5_r) + $signed({{6{cfg.disp_u[31]}}, cfg.disp_u, 14'd0})
          + $signed({8'd0, cx5_r, 30'd0}) + 52'sd8192;
    mys = 52'(ry5_r) + $signed({{6{cfg.disp_v[31]}}, cfg.disp_v, 14'd0})
          + $signed({8'd0, cy5_r, 30'd0}) + 52'sd8192;
    nry = -ry5_r;
    shear_sum = 53'(exdy5_r) + 53'(eydx5_r);
    s6_nxt.mx   = $signed(mxs[51:14]);
    s6_nxt.my   = $signed(mys[51:14]);
    s6_nxt.tal  = ggx5_r * $signed({1'b0, nry[23:0]});
    s6_nxt.tah  = ggx5_r * $signed(nry[49:24]);
    s6_nxt.tbl  = ggy5_r * $signed({1'b0, rx5_r[23:0]});
    s6_nxt.tbh  = ggy5_r * $signed(rx5_r[49:24]);
    s6_nxt.texx = sat_term(64'(exdx5_r));
    s6_nxt.teyy = sat_term(64'(eydy5_r));
    s6_nxt.tsh  = sat_term(64'(shear_sum));
    s6_nxt.ggx  = ggx5_r;
    s6_nxt.ggy  = ggy5_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cbx4_r <= cbx_nxt;
      sby4_r <= sby_nxt;
      sbx4_r <= sbx_nxt;
      cby4_r <= cby_nxt;
      ex4_r  <= ex_nxt;
      ey4_r  <= ey_nxt;
      ggx4_r <= s3.ggx;
      ggy4_r <= s3.ggy;
      dx4_r  <= s3.dx;
      dy4_r  <= s3.dy;
      cx4_r  <= s3.cx;
      cy4_r  <= s3.cy;
    end
    if (en[1]) begin
      rx5_r   <= rx_nxt;
      ry5_r   <= ry_nxt;
      exdx5_r <= exdx_nxt;
      eydy5_r <= eydy_nxt;
      exdy5_r <= exdy_nxt;
      eydx5_r <= eydx_nxt;
      ggx5_r  <= ggx4_r;
      ggy5_r  <= ggy4_r;
      cx5_r   <= cx4_r;
      cy5_r   <= cy4_r;
    end
    if (en[2]) begin
      s6_r <= s6_nxt;
    end
  end

  assign s6 = s6_r;

endmodule

FILE: hw/rtl/aswg_back.sv
// Stages seven and eight: rotation term assembly, rounding, saturation and the
// result register. Depends on aswg_pkg.
module aswg_back (
  input  logic           clk,
  input  logic [1:0]     en,
  input  aswg_pkg::s6_t  s6,
  output aswg_pkg::res_t res
);
  import aswg_pkg::*;

  logic signed [84:0] tra_nxt, trb_nxt, tra7_r, trb7_r;
  logic signed [37:0] mx7_r, my7_r;
  logic signed [TERM_W-1:0] texx7_r, teyy7_r, tsh7_r;
  logic signed [34:0] ggx7_r, ggy7_r;

  logic signed [84:0] rtra, rtrb;
  logic signed [54:0] trot;
  res_t res_nxt;
  res_t res_r;

  assign tra_nxt = {s6.tah, 24'd0} + 85'($signed(s6.tal));
  assign trb_nxt = {s6.tbh, 24'd0} + 85'($signed(s6.tbl));

  always_comb begin
    rtra = tra7_r + 85'sd536870912;
    rtrb = trb7_r + 85'sd536870912;
    trot = $signed(rtra[84:30]) + $signed(rtrb[84:30]);
    res_nxt.mapped_x   = sat_map(64'(mx7_r));
    res_nxt.mapped_y   = sat_map(64'(my7_r));
    res_nxt.term_u     = sat_term(64'(ggx7_r));
    res_nxt.term_v     = sat_term(64'(ggy7_r));
    res_nxt.term_rot   = sat_term(64'(trot));
    res_nxt.term_exx   = texx7_r;
    res_nxt.term_eyy   = teyy7_r;
    res_nxt.term_shear = tsh7_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tra7_r  <= tra_nxt;
      trb7_r  <= trb_nxt;
      mx7_r   <= s6.mx;
      my7_r   <= s6.my;
      texx7_r <= s6.texx;
      teyy7_r <= s6.teyy;
      tsh7_r  <= s6.tsh;
      ggx7_r  <= s6.ggx;
      ggy7_r  <= s6.ggy;
    end
    if (en[1]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: hw/rtl/affine_subset_warp_and_gradient_terms.sv
// Affine subset warp and gradient terms. Each transfer on in_ch carries one pixel of a
// correlation subset with its centre and image gradient; each transfer on out_ch returns
// the warped position and the six gradient terms for that pixel, in order. The datapath
// is an eight-stage pipeline in which every stage holds one rank of multipliers of about
// 32 by 32 bits or one wide add, so one pixel is accepted every clock cycle while out_ch
// is not stalled. Under stall, empty stages close up before in_ch is held off. The
// rotation cosine and sine, the stretch, shear and displacement registers sit on cfg_ch
// (index 0 to 6, always ready); the user must write them only while no pixel is in
// flight, and the block itself does not enforce this. Depends on aswg_pkg and aswg_ifs.
module affine_subset_warp_and_gradient_terms (
  input logic         clk,
  input logic         rst_n,
  aswg_in_if.sink     in_ch,
  aswg_out_if.source  out_ch,
  aswg_cfg_if.sink    cfg_ch
);
  import aswg_pkg::*;

  cfg_t     cfg;
  stg_vec_t en;
  s3_t      s3;
  s6_t      s6;
  res_t     res;

  aswg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg_ready (cfg_ch.ready),
    .cfg       (cfg)
  );

  aswg_pipe_ctl u_pipe_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .en        (en)
  );

  aswg_front u_front (
    .clk          (clk),
    .en           (en[2:0]),
    .cfg          (cfg),
    .pix_x        (in_ch.pix_x),
    .pix_y        (in_ch.pix_y),
    .centre_x     (in_ch.centre_x),
    .centre_y     (in_ch.centre_y),
    .grad_x       (in_ch.grad_x),
    .grad_y       (in_ch.grad_y),
    .rotate_grads (in_ch.rotate_grads),
    .s3           (s3)
  );

  aswg_mid u_mid (
    .clk (clk),
    .en  (en[5:3]),
    .cfg (cfg),
    .s3  (s3),
    .s6  (s6)
  );

  aswg_back u_back (
    .clk (clk),
    .en  (en[7:6]),
    .s6  (s6),
    .res (res)
  );

  assign out_ch.mapped_x   = res.mapped_x;
  assign out_ch.mapped_y   = res.mapped_y;
  assign out_ch.term_u     = res.term_u;
  assign out_ch.term_v     = res.term_v;
  assign out_ch.term_rot   = res.term_rot;
  assign out_ch.term_exx   = res.term_exx;
  assign out_ch.term_eyy   = res.term_eyy;
  assign out_ch.term_shear = res.term_shear;

endmodule
